/* src/ake_pkg.sv */
package ake_pkg;

  localparam int WORD_W        = 64;
  localparam int NUM_WORDS     = 4;
  localparam int KEY_W         = WORD_W * NUM_WORDS;
  localparam int LEN_W         = 6;
  localparam int CNT_W         = 7;
  localparam int RESULT_LIMIT  = 64;
  localparam int MAX_COUNT_DEF = 64;
  localparam int KEY_BYTES_DEF = 32;

  localparam logic [7:0] ASCII_ZERO = 8'h30;
  localparam logic [3:0] DEC_NINE   = 4'd9;

  // Decimal form of the current index; at most two digits since a run tops out at 64.
  typedef struct packed {
    logic [LEN_W-1:0] base_len;
    logic [3:0]       tens;
    logic [3:0]       ones;
  } ake_idx_t;

endpackage

/* src/ake_digit_insert.sv */
module ake_digit_insert #(
  parameter int KEY_BYTES = ake_pkg::KEY_BYTES_DEF
) (
  input  logic [ake_pkg::KEY_W-1:0] key_i,
  input  ake_pkg::ake_idx_t         idx_i,
  output logic [ake_pkg::KEY_W-1:0] key_o,
  output logic [ake_pkg::LEN_W-1:0] len_o
);
  import ake_pkg::*;

  logic             two_dig;
  logic [7:0]       first_chr;
  logic [7:0]       second_chr;
  logic [LEN_W:0]   pos1;
  logic [LEN_W:0]   len_raw;

  assign two_dig    = (idx_i.tens != 4'd0);
  assign first_chr  = ASCII_ZERO | {4'd0, (two_dig ? idx_i.tens : idx_i.ones)};
  assign second_chr = ASCII_ZERO | {4'd0, idx_i.ones};
  assign pos1       = {1'b0, idx_i.base_len} + {{LEN_W{1'b0}}, 1'b1};
  assign len_raw    = {1'b0, idx_i.base_len} + (two_dig ? (LEN_W+1)'(2) : (LEN_W+1)'(1));

  always_comb begin
    key_o = key_i;
    // Byte 0 sits in the top byte of the flat key.
    for (int b = 0; b < KEY_BYTES; b++) begin
      if ({1'b0, idx_i.base_len} == (LEN_W+1)'(b)) begin
        key_o[KEY_W-1-8*b -: 8] = first_chr;
      end else if (two_dig && pos1 == (LEN_W+1)'(b)) begin
        key_o[KEY_W-1-8*b -: 8] = second_chr;
      end
    end
  end

  assign len_o = (len_raw > (LEN_W+1)'(KEY_BYTES)) ? LEN_W'(KEY_BYTES) : len_raw[LEN_W-1:0];

endmodule

/* src/array_key_expander_unit.sv */
// A request loads the run registers on transfer; its results then go to the output register.
// Throughput: one result per cycle while the output is not stalled; a run holds off the input
// until its last result, and the next request is taken in the cycle that result is emitted.
// A zero count is taken and produces nothing.
// Reset (rst_ni low, asynchronous) drops any run in progress and empties the output register.
module array_key_expander_unit #(
  parameter int MAX_COUNT = ake_pkg::MAX_COUNT_DEF,
  parameter int KEY_BYTES = ake_pkg::KEY_BYTES_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [ake_pkg::WORD_W-1:0]  base_key_word0_i,
  input  logic [ake_pkg::WORD_W-1:0]  base_key_word1_i,
  input  logic [ake_pkg::WORD_W-1:0]  base_key_word2_i,
  input  logic [ake_pkg::WORD_W-1:0]  base_key_word3_i,
  input  logic [ake_pkg::LEN_W-1:0]   base_length_i,
  input  logic [ake_pkg::CNT_W-1:0]   element_count_i,
  input  logic [ake_pkg::WORD_W-1:0]  delta_value_i,
  input  logic [ake_pkg::WORD_W-1:0]  net_metadata_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [ake_pkg::WORD_W-1:0]  out_key_word0_o,
  output logic [ake_pkg::WORD_W-1:0]  out_key_word1_o,
  output logic [ake_pkg::WORD_W-1:0]  out_key_word2_o,
  output logic [ake_pkg::WORD_W-1:0]  out_key_word3_o,
  output logic [ake_pkg::LEN_W-1:0]   out_length_o,
  output logic [ake_pkg::WORD_W-1:0]  out_delta_o,
  output logic [ake_pkg::WORD_W-1:0]  out_metadata_o,
  output logic                        last_of_run_o
);
  import ake_pkg::*;

  localparam int CntMax = (MAX_COUNT < RESULT_LIMIT) ? MAX_COUNT : RESULT_LIMIT;

  // run state
  logic             busy_q;
  logic [CNT_W-1:0] tgt_q, cur_q;
  logic [3:0]       tens_q, ones_q;
  logic [KEY_W-1:0] key_q;
  logic [LEN_W-1:0] len_q;
  logic [WORD_W-1:0] delta_q, meta_q;

  // output register
  logic              out_valid_q;
  logic [KEY_W-1:0]  out_key_q;
  logic [LEN_W-1:0]  out_len_q;
  logic [WORD_W-1:0] out_delta_q, out_meta_q;
  logic              out_last_q;

  logic             emit, is_last, in_xfer;
  logic [CNT_W-1:0] cnt_sat;
  ake_idx_t         idx;
  logic [KEY_W-1:0] key_exp;
  logic [LEN_W-1:0] len_exp;

  assign emit       = busy_q && (!out_valid_q || out_ready_i);
  assign is_last    = (cur_q == tgt_q);
  assign in_ready_o = !busy_q || (emit && is_last);
  assign in_xfer    = in_valid_i && in_ready_o;
  assign cnt_sat    = (element_count_i > CNT_W'(CntMax)) ? CNT_W'(CntMax) : element_count_i;

  assign idx.base_len = len_q;
  assign idx.tens     = tens_q;
  assign idx.ones     = ones_q;

  ake_digit_insert #(
    .KEY_BYTES(KEY_BYTES)
  ) u_ins (
    .key_i (key_q),
    .idx_i (idx),
    .key_o (key_exp),
    .len_o (len_exp)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      tgt_q       <= '0;
      cur_q       <= '0;
      tens_q      <= '0;
      ones_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      // a new request overrides the run that just finished
      if (in_xfer) begin
        busy_q <= (cnt_sat != '0);
        tgt_q  <= cnt_sat;
        cur_q  <= CNT_W'(1);
        tens_q <= 4'd0;
        ones_q <= 4'd1;
      end else if (emit) begin
        if (is_last) begin
          busy_q <= 1'b0;
        end else begin
          cur_q <= cur_q + CNT_W'(1);
          if (ones_q == DEC_NINE) begin
            ones_q <= 4'd0;
            tens_q <= tens_q + 4'd1;
          end else begin
            ones_q <= ones_q + 4'd1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      key_q   <= {base_key_word0_i, base_key_word1_i, base_key_word2_i, base_key_word3_i};
      len_q   <= base_length_i;
      delta_q <= delta_value_i;
      meta_q  <= net_metadata_i;
    end
    if (emit) begin
      out_key_q   <= key_exp;
      out_len_q   <= len_exp;
      out_delta_q <= delta_q;
      out_meta_q  <= meta_q;
      out_last_q  <= is_last;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign out_key_word0_o = out_key_q[4*WORD_W-1 -: WORD_W];
  assign out_key_word1_o = out_key_q[3*WORD_W-1 -: WORD_W];
  assign out_key_word2_o = out_key_q[2*WORD_W-1 -: WORD_W];
  assign out_key_word3_o = out_key_q[WORD_W-1 -: WORD_W];
  assign out_length_o    = out_len_q;
  assign out_delta_o     = out_delta_q;
  assign out_metadata_o  = out_meta_q;
  assign last_of_run_o   = out_last_q;

endmodule

/* src/ake_checker.sv */
module ake_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_valid_i,
  input logic                        in_ready_o,
  input logic [ake_pkg::WORD_W-1:0]  base_key_word0_i,
  input logic [ake_pkg::WORD_W-1:0]  base_key_word1_i,
  input logic [ake_pkg::WORD_W-1:0]  base_key_word2_i,
  input logic [ake_pkg::WORD_W-1:0]  base_key_word3_i,
  input logic [ake_pkg::LEN_W-1:0]   base_length_i,
  input logic [ake_pkg::CNT_W-1:0]   element_count_i,
  input logic [ake_pkg::WORD_W-1:0]  delta_value_i,
  input logic [ake_pkg::WORD_W-1:0]  net_metadata_i,
  input logic                        out_valid_o,
  input logic                        out_ready_i,
  input logic [ake_pkg::WORD_W-1:0]  out_key_word0_o,
  input logic [ake_pkg::WORD_W-1:0]  out_key_word1_o,
  input logic [ake_pkg::WORD_W-1:0]  out_key_word2_o,
  input logic [ake_pkg::WORD_W-1:0]  out_key_word3_o,
  input logic [ake_pkg::LEN_W-1:0]   out_length_o,
  input logic [ake_pkg::WORD_W-1:0]  out_delta_o,
  input logic [ake_pkg::WORD_W-1:0]  out_metadata_o,
  input logic                        last_of_run_o
);

  // waiting request holds
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_ready_o |=> in_valid_i && $stable(base_key_word0_i)
      && $stable(base_key_word1_i) && $stable(base_key_word2_i)
      && $stable(base_key_word3_i) && $stable(base_length_i)
      && $stable(element_count_i) && $stable(delta_value_i) && $stable(net_metadata_i))
    else $error("waiting request changed");

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_key_word0_o)
      && $stable(out_key_word1_o) && $stable(out_key_word2_o)
      && $stable(out_key_word3_o) && $stable(out_length_o) && $stable(out_delta_o)
      && $stable(out_metadata_o) && $stable(last_of_run_o))
    else $error("stalled result changed");

  // a run never pauses: a transfer that is not the last is followed by the next result
  a_run_cont: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && !last_of_run_o |=> out_valid_o)
    else $error("run stopped before its last result");

  // input stays closed while a run is stalled mid-way
  a_no_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i && !last_of_run_o |-> !in_ready_o)
    else $error("input open during a stalled run");

endmodule

bind array_key_expander_unit ake_checker u_ake_checker (.*);

/* test/tb_top.sv */
`timescale 1ns / 100ps

module tb_top;
  import ake_pkg::*;

  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int LONG_HOLD   = 300;
  localparam int PHASE_ITEMS = 58;

  typedef struct packed {
    logic [NUM_WORDS-1:0][WORD_W-1:0] key;
    logic [LEN_W-1:0]                 len;
    logic [CNT_W-1:0]                 cnt;
    logic [WORD_W-1:0]                delta;
    logic [WORD_W-1:0]                meta;
  } array_add_t;

  typedef struct packed {
    logic [NUM_WORDS-1:0][WORD_W-1:0] key;
    logic [LEN_W-1:0]                 len;
    logic [WORD_W-1:0]                delta;
    logic [WORD_W-1:0]                meta;
    logic                             last;
  } elem_add_t;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              in_valid_i = 1'b0;
  logic              in_ready_o;
  logic [WORD_W-1:0] base_key_word0_i = '0;
  logic [WORD_W-1:0] base_key_word1_i = '0;
  logic [WORD_W-1:0] base_key_word2_i = '0;
  logic [WORD_W-1:0] base_key_word3_i = '0;
  logic [LEN_W-1:0]  base_length_i = '0;
  logic [CNT_W-1:0]  element_count_i = '0;
  logic [WORD_W-1:0] delta_value_i = '0;
  logic [WORD_W-1:0] net_metadata_i = '0;
  logic              out_valid_o;
  logic              out_ready_i = 1'b0;
  logic [WORD_W-1:0] out_key_word0_o;
  logic [WORD_W-1:0] out_key_word1_o;
  logic [WORD_W-1:0] out_key_word2_o;
  logic [WORD_W-1:0] out_key_word3_o;
  logic [LEN_W-1:0]  out_length_o;
  logic [WORD_W-1:0] out_delta_o;
  logic [WORD_W-1:0] out_metadata_o;
  logic              last_of_run_o;

  array_add_t pending_adds [$];
  elem_add_t  expected_adds [$];
  array_add_t cur_add;
  elem_add_t  got_add;
  logic       drv_busy;

  int send_idle_pct = 0;
  int stall_pct     = 0;
  int hold_req      = 0;
  int hold_seen     = 0;
  int hold_left     = 0;
  int fail_cnt      = 0;
  int cycle_cnt     = 0;
  int ph;
  int n;

  int phase_send_idle [4] = '{0, 63, 0, 36};
  int phase_stall     [4] = '{0, 0, 63, 36};

  array_key_expander_unit dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .base_key_word0_i(base_key_word0_i),
    .base_key_word1_i(base_key_word1_i),
    .base_key_word2_i(base_key_word2_i),
    .base_key_word3_i(base_key_word3_i),
    .base_length_i   (base_length_i),
    .element_count_i (element_count_i),
    .delta_value_i   (delta_value_i),
    .net_metadata_i  (net_metadata_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .out_key_word0_o (out_key_word0_o),
    .out_key_word1_o (out_key_word1_o),
    .out_key_word2_o (out_key_word2_o),
    .out_key_word3_o (out_key_word3_o),
    .out_length_o    (out_length_o),
    .out_delta_o     (out_delta_o),
    .out_metadata_o  (out_metadata_o),
    .last_of_run_o   (last_of_run_o)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  // Builds the element requests for one array add: the index digits are written
  // over a running copy of the key, so longer numbers cover shorter ones.
  task automatic expand_array_add(input array_add_t rq);
    logic [7:0] kb [32];
    elem_add_t  ea;
    int         b, idx, run_len, nd, q, i, pos, tot;
    int         dig [5];
    begin
      for (b = 0; b < 32; b++) kb[b] = rq.key[b / 8][(7 - b % 8) * 8 +: 8];
      run_len = int'(rq.cnt);
      if (run_len > MAX_COUNT_DEF) run_len = MAX_COUNT_DEF;
      if (run_len > RESULT_LIMIT) run_len = RESULT_LIMIT;
      for (idx = 1; idx <= run_len; idx++) begin
        if (idx < 10) nd = 1;
        else if (idx < 100) nd = 2;
        else if (idx < 1000) nd = 3;
        else if (idx < 10000) nd = 4;
        else nd = 5;
        q = idx;
        for (i = nd - 1; i >= 0; i--) begin
          dig[i] = q % 10;
          q = q / 10;
        end
        for (i = 0; i < nd; i++) begin
          pos = int'(rq.len) + i;
          if (pos < KEY_BYTES_DEF && pos < 32) kb[pos] = 8'(int'(ASCII_ZERO) + dig[i]);
        end
        tot = int'(rq.len) + nd;
        if (tot > KEY_BYTES_DEF) tot = KEY_BYTES_DEF;
        for (b = 0; b < 32; b++) ea.key[b / 8][(7 - b % 8) * 8 +: 8] = kb[b];
        ea.len   = LEN_W'(tot);
        ea.delta = rq.delta;
        ea.meta  = rq.meta;
        ea.last  = (idx == run_len);
        expected_adds.push_back(ea);
      end
    end
  endtask

  function automatic logic [WORD_W-1:0] rand_word();
    int sel;
    begin
      sel = $urandom_range(9);
      if (sel == 0) return '0;
      if (sel == 1) return '1;
      return {$urandom, $urandom};
    end
  endfunction

  function automatic array_add_t rand_array_add();
    array_add_t r;
    int         sel;
    begin
      for (int w = 0; w < NUM_WORDS; w++) r.key[w] = rand_word();
      sel = $urandom_range(99);
      if (sel < 60) r.len = LEN_W'($urandom_range(32));
      else if (sel < 85) r.len = LEN_W'($urandom_range(32, 24));
      else r.len = LEN_W'($urandom_range(63, 33));
      sel = $urandom_range(99);
      if (sel < 55) r.cnt = CNT_W'($urandom_range(12));
      else if (sel < 75) r.cnt = CNT_W'($urandom_range(64, 13));
      else if (sel < 85) r.cnt = CNT_W'($urandom_range(127, 65));
      else if (sel < 92) r.cnt = CNT_W'(MAX_COUNT_DEF);
      else r.cnt = '0;
      r.delta = rand_word();
      r.meta  = rand_word();
      return r;
    end
  endfunction

  task automatic push_add(input logic [WORD_W-1:0] k0, input logic [WORD_W-1:0] k1,
                          input logic [WORD_W-1:0] k2, input logic [WORD_W-1:0] k3,
                          input int len, input int cnt,
                          input logic [WORD_W-1:0] d, input logic [WORD_W-1:0] m);
    array_add_t r;
    begin
      r.key[0] = k0;
      r.key[1] = k1;
      r.key[2] = k2;
      r.key[3] = k3;
      r.len    = LEN_W'(len);
      r.cnt    = CNT_W'(cnt);
      r.delta  = d;
      r.meta   = m;
      pending_adds.push_back(r);
    end
  endtask

  // Wait until every queued add has transferred and all its elements are out.
  // Checked on the falling edge, once the driver and monitor have settled.
  task automatic drain();
    begin
      while (pending_adds.size() != 0 || in_valid_i) @(negedge clk_i);
      while (expected_adds.size() != 0) @(negedge clk_i);
    end
  endtask

  task automatic check_field(input string name, input logic [WORD_W-1:0] exp_v,
                             input logic [WORD_W-1:0] act_v);
    begin
      if (exp_v !== act_v) begin
        $display("%0t: %s mismatch: expected %h, actual %h", $time, name, exp_v, act_v);
        fail_cnt++;
      end
    end
  endtask

  // Driver: one array add offered at a time, held until transfer.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      drv_busy = in_valid_i;
      if (in_valid_i && in_ready_o) begin
        expand_array_add(cur_add);
        drv_busy = 1'b0;
      end
      if (!drv_busy) begin
        if (pending_adds.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          cur_add = pending_adds.pop_front();
          base_key_word0_i <= cur_add.key[0];
          base_key_word1_i <= cur_add.key[1];
          base_key_word2_i <= cur_add.key[2];
          base_key_word3_i <= cur_add.key[3];
          base_length_i    <= cur_add.len;
          element_count_i  <= cur_add.cnt;
          delta_value_i    <= cur_add.delta;
          net_metadata_i   <= cur_add.meta;
          in_valid_i       <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Receiver ready, with an occasional long hold-off on request.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      hold_left   <= 0;
      hold_seen   <= 0;
    end else if (hold_left != 0) begin
      hold_left   <= hold_left - 1;
      out_ready_i <= 1'b0;
    end else if (hold_seen != hold_req) begin
      hold_seen   <= hold_req;
      hold_left   <= LONG_HOLD;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Monitor
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_adds.size() == 0) begin
        $display("%0t: unexpected element request: expected none, actual key0=%h len=%0d",
                 $time, out_key_word0_o, out_length_o);
        fail_cnt++;
      end else begin
        got_add = expected_adds.pop_front();
        check_field("out_key_word0", got_add.key[0], out_key_word0_o);
        check_field("out_key_word1", got_add.key[1], out_key_word1_o);
        check_field("out_key_word2", got_add.key[2], out_key_word2_o);
        check_field("out_key_word3", got_add.key[3], out_key_word3_o);
        check_field("out_length", WORD_W'(got_add.len), WORD_W'(out_length_o));
        check_field("out_delta", got_add.delta, out_delta_o);
        check_field("out_metadata", got_add.meta, out_metadata_o);
        check_field("last_of_run", WORD_W'(got_add.last), WORD_W'(last_of_run_o));
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: field extremes, zero and saturating counts, digits running off the key.
    push_add('0, '0, '0, '0, 0, 1, '0, '0);
    push_add('1, '1, '1, '1, 0, 9, '1, '1);
    push_add(64'h6974656d3a000000, '0, '0, '0, 5, 10, 64'd1, 64'd2);
    push_add({$urandom, $urandom}, '1, '0, '1, 8, 0, '1, '0);
    push_add('1, '0, '1, '0, 12, 64, 64'h8000_0000_0000_0000, 64'h1);
    push_add('0, '1, '0, '1, 3, 127, '1, 64'h8000_0000_0000_0000);
    push_add('1, '1, '1, '1, 65, 1, '0, '1);
    push_add('1, '1, '1, '1, 31, 12, 64'h0123_4567_89ab_cdef, 64'hfedc_ba98_7654_3210);
    push_add('0, '0, '0, '0, 30, 11, '0, '0);
    push_add('1, '1, '1, '1, 32, 3, '1, '1);
    push_add('0, '0, '0, '0, 33, 2, '0, '1);
    push_add('1, '1, '1, '1, 63, 64, '1, '0);
    push_add('0, '0, '0, '0, 0, 0, '0, '0);
    push_add('0, '0, '0, '0, 63, 127, '1, '1);
    push_add('1, '1, '1, '1, 16, 100, '0, '0);
    push_add('0, '1, '0, '1, 24, 1, '0, '1);
    drain();

    for (ph = 0; ph < 4; ph++) begin
      send_idle_pct <= phase_send_idle[ph];
      stall_pct     <= phase_stall[ph];
      @(posedge clk_i);
      for (n = 0; n < PHASE_ITEMS; n++) pending_adds.push_back(rand_array_add());
      drain();
    end

    // Receiver holds off while the sender keeps offering, so the block backs up.
    send_idle_pct <= 0;
    stall_pct     <= 0;
    @(posedge clk_i);
    for (n = 0; n < 12; n++) push_add(rand_word(), rand_word(), rand_word(), rand_word(),
                                      $urandom_range(32), $urandom_range(20, 5),
                                      rand_word(), rand_word());
    hold_req <= hold_req + 1;
    drain();

    repeat (16) @(posedge clk_i);
    if (fail_cnt == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
